// ===== rtl/core/lkvc_pkg.sv =====
package lkvc_pkg;

	localparam int CAP_W          = 5;
	localparam int RESET_CAPACITY = 16;
	localparam logic signed [31:0] NOT_FOUND = -32'sd1;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_word_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_data;
		logic               evicted;
	} rsp_word_t;

	typedef struct packed {
		logic [CAP_W-1:0] capacity;
	} cfg_word_t;

	// which cell a commit addresses
	typedef enum logic [1:0] {
		TGT_NONE,
		TGT_HIT,
		TGT_FREE,
		TGT_LRU
	} target_t;

	// search word rippling down the chain
	typedef struct packed {
		logic               hit;
		logic               free;
		logic               lru;
		logic signed [31:0] data;
	} srch_t;

	// commit broadcast to every cell
	typedef struct packed {
		logic    upd;
		target_t target;
		logic    age;
		logic    wr_key;
		logic    wr_data;
	} cmd_t;

endpackage

// ===== rtl/core/lkvc_chan_if.sv =====
interface lkvc_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lkvc_cell.sv =====
module lkvc_cell #(
	parameter int RW = 4,
	parameter int CW = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 prev_tok,
	input  lkvc_pkg::srch_t      prev_srch,
	input  logic [RW-1:0]        prev_rank,
	output logic                 next_tok,
	output lkvc_pkg::srch_t      next_srch,
	output logic [RW-1:0]        next_rank,
	input  lkvc_pkg::cmd_t       cmd,
	input  logic [CW-1:0]        age_limit,
	input  logic [CW-1:0]        lru_rank,
	input  logic signed [31:0]   key,
	input  logic signed [31:0]   value
);
	import lkvc_pkg::*;

	logic               valid_q;
	logic [RW-1:0]      rank_q;
	logic signed [31:0] key_q;
	logic signed [31:0] data_q;
	logic               tok_q;
	srch_t              srch_q;
	logic [RW-1:0]      hrank_q;
	logic               sel_hit_q, sel_free_q, sel_lru_q;
	logic               mine_hit, mine_free, mine_lru, is_target;

	// first match / first free / least recent, earlier cells win
	assign mine_hit  = valid_q && (key_q == key) && !prev_srch.hit;
	assign mine_free = !valid_q && !prev_srch.free;
	assign mine_lru  = valid_q && (CW'(rank_q) == lru_rank) && !prev_srch.lru;

	always_comb begin
		case (cmd.target)
			TGT_HIT:  is_target = sel_hit_q;
			TGT_FREE: is_target = sel_free_q;
			TGT_LRU:  is_target = sel_lru_q;
			default:  is_target = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= prev_tok;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_tok) begin
			srch_q.hit  <= prev_srch.hit | mine_hit;
			srch_q.free <= prev_srch.free | mine_free;
			srch_q.lru  <= prev_srch.lru | mine_lru;
			srch_q.data <= mine_hit ? data_q : prev_srch.data;
			hrank_q     <= mine_hit ? rank_q : prev_rank;
			sel_hit_q   <= mine_hit;
			sel_free_q  <= mine_free;
			sel_lru_q   <= mine_lru;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (cmd.upd) begin
			if (is_target) begin
				rank_q <= '0;
				if (cmd.wr_key) begin
					valid_q <= 1'b1;
				end
			end else if (cmd.age && valid_q && (CW'(rank_q) < age_limit)) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && is_target) begin
			if (cmd.wr_key) begin
				key_q <= key;
			end
			if (cmd.wr_data) begin
				data_q <= value;
			end
		end
	end

	assign next_tok  = tok_q;
	assign next_srch = srch_q;
	assign next_rank = hrank_q;

endmodule

// ===== rtl/core/lru_key_value_cache_unit.sv =====
// LRU key-value cache, fully associative, one entry per cell.
// req  (sink):   word of operation (0 get, 1 put), key, value.
// rsp  (source): word of hit, read_data (-1 unless a get hits), evicted.
// cfg  (sink):   capacity, taken only while the cache is empty; clamped
//                to 1..ENTRIES. Always ready.
// A request is accepted when the cache is idle. A search token then walks
// the cell chain, one cell per cycle, picking up the first matching key,
// the first free cell and the least recent cell. When the token leaves the
// tail, the state moves to commit, where (once the output register is free)
// the commit is broadcast to every cell and the result word is registered.
// A new request is taken only once the previous one has committed and the
// cache is idle again; the length of the cell chain sets the rate.
// If rsp is stalled, the finished request waits at commit with the cache
// state untouched until the output register frees.
// Reset: all entries invalid, ranks zero, occupancy zero, capacity
// min(16, ENTRIES). Keys and data are not cleared.
module lru_key_value_cache_unit #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	lkvc_chan_if.sink   req,
	lkvc_chan_if.source rsp,
	lkvc_chan_if.sink   cfg
);
	import lkvc_pkg::*;

	localparam int RW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW      = $clog2(ENTRIES + 1);
	localparam int RST_CAP = (ENTRIES < RESET_CAPACITY) ? ENTRIES : RESET_CAPACITY;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMMIT
	} state_t;

	state_t          state_q;
	req_word_t       req_q;
	logic            start_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   cap_q;
	rsp_word_t       out_q;
	logic            out_valid_q;

	// chain taps
	logic            tok   [ENTRIES+1];
	srch_t           srch  [ENTRIES+1];
	logic [RW-1:0]   hrank [ENTRIES+1];

	cmd_t            cmd;
	logic [CW-1:0]   age_limit;
	logic [CW-1:0]   lru_rank;
	logic [CW-1:0]   cnt_nxt;
	rsp_word_t       result;
	logic            commit_go;
	logic            evict_due;
	srch_t           fin;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	assign commit_go = (state_q == ST_COMMIT) && (!out_valid_q || rsp.ready);
	assign lru_rank  = cnt_q - 1'b1;
	assign evict_due = (cnt_q >= cap_q) && (cnt_q != '0);
	assign fin       = srch[ENTRIES];

	// head of the chain
	assign tok[0]   = start_q;
	assign srch[0]  = '0;
	assign hrank[0] = '0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lkvc_cell #(
			.RW (RW),
			.CW (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.prev_tok  (tok[g]),
			.prev_srch (srch[g]),
			.prev_rank (hrank[g]),
			.next_tok  (tok[g+1]),
			.next_srch (srch[g+1]),
			.next_rank (hrank[g+1]),
			.cmd       (cmd),
			.age_limit (age_limit),
			.lru_rank  (lru_rank),
			.key       (req_q.key),
			.value     (req_q.value)
		);
	end

	// commit decision from the search word at the tail
	always_comb begin
		cmd.upd          = commit_go;
		cmd.target       = TGT_NONE;
		cmd.age          = 1'b0;
		cmd.wr_key       = 1'b0;
		cmd.wr_data      = 1'b0;
		age_limit        = cnt_q;
		cnt_nxt          = cnt_q;
		result.hit       = 1'b0;
		result.read_data = NOT_FOUND;
		result.evicted   = 1'b0;
		if (fin.hit) begin
			cmd.target  = TGT_HIT;
			cmd.age     = 1'b1;
			cmd.wr_data = req_q.operation;
			age_limit   = CW'(hrank[ENTRIES]);
			result.hit  = 1'b1;
			if (!req_q.operation) begin
				result.read_data = fin.data;
			end
		end else if (req_q.operation) begin
			if (evict_due) begin
				if (fin.lru) begin
					cmd.target     = TGT_LRU;
					cmd.age        = 1'b1;
					cmd.wr_key     = 1'b1;
					cmd.wr_data    = 1'b1;
					result.evicted = 1'b1;
				end
			end else if (fin.free) begin
				cmd.target  = TGT_FREE;
				cmd.age     = 1'b1;
				cmd.wr_key  = 1'b1;
				cmd.wr_data = 1'b1;
				cnt_nxt     = cnt_q + 1'b1;
				age_limit   = cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						start_q <= 1'b1;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (tok[ENTRIES]) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (commit_go) begin
						out_valid_q <= 1'b1;
						cnt_q       <= cnt_nxt;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.data;
		end
		if (commit_go) begin
			out_q <= result;
		end
	end

	// capacity: only while empty, clamped to 1..ENTRIES
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CW'(RST_CAP);
		end else if (cfg.valid && cnt_q == '0) begin
			if (cfg.data.capacity == '0) begin
				cap_q <= CW'(1);
			end else if (int'(cfg.data.capacity) > ENTRIES) begin
				cap_q <= CW'(ENTRIES);
			end else begin
				cap_q <= CW'(cfg.data.capacity);
			end
		end
	end

	a_cnt_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cap_q)
		else $error("occupancy above capacity");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({start_q, tok[ENTRIES]}) && !(start_q && state_q != ST_SEARCH))
		else $error("search token overlap");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go && result.evicted |-> !result.hit && cnt_q == cap_q)
		else $error("eviction while not full or on a hit");

endmodule

// ===== dv/lru_key_value_cache_unit_tb.sv =====
`timescale 1ns / 1ps

package lkvc_tb_pkg;
	import lkvc_pkg::*;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;
	localparam int   SLOTS  = 16;

	// Shadow of the cache contents and recency order, plus the response
	// words still owed by the block.
	class lru_mirror;
		bit               used   [SLOTS];
		bit signed [31:0] tag    [SLOTS];
		bit signed [31:0] stored [SLOTS];
		int               age    [SLOTS];
		int               occupancy;
		int               capacity;
		rsp_word_t        words_due [$];
		int               errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				used[i]   = 1'b0;
				tag[i]    = '0;
				stored[i] = '0;
				age[i]    = 0;
			end
			occupancy = 0;
			capacity  = (RESET_CAPACITY > SLOTS) ? SLOTS : RESET_CAPACITY;
			errors    = 0;
		endfunction

		// ignored unless the cache is empty; clamped to 1..SLOTS
		function void write_capacity(logic [CAP_W-1:0] v);
			if (occupancy != 0)
				return;
			if (v == 0)
				capacity = 1;
			else if (v > SLOTS)
				capacity = SLOTS;
			else
				capacity = v;
		endfunction

		function void grow_older(int limit);
			for (int i = 0; i < SLOTS; i++)
				if (used[i] && age[i] < limit)
					age[i]++;
		endfunction

		function rsp_word_t lookup_and_update(req_word_t w);
			rsp_word_t r;
			int        slot;
			slot        = -1;
			r.hit       = 1'b0;
			r.read_data = NOT_FOUND;
			r.evicted   = 1'b0;
			for (int i = 0; i < SLOTS; i++)
				if (slot < 0 && used[i] && tag[i] == w.key)
					slot = i;
			if (slot >= 0) begin
				r.hit = 1'b1;
				grow_older(age[slot]);
				age[slot] = 0;
				if (w.operation == OP_GET)
					r.read_data = stored[slot];
				else
					stored[slot] = w.value;
			end else if (w.operation == OP_PUT) begin
				if (occupancy >= capacity && occupancy != 0) begin
					// least recent entry gives up its slot
					for (int i = 0; i < SLOTS; i++)
						if (slot < 0 && used[i] && age[i] == occupancy - 1)
							slot = i;
					if (slot >= 0) begin
						r.evicted  = 1'b1;
						used[slot] = 1'b0;
					end
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (slot < 0 && !used[i])
							slot = i;
					if (slot >= 0)
						occupancy++;
				end
				if (slot >= 0) begin
					grow_older(occupancy);
					used[slot]   = 1'b1;
					tag[slot]    = w.key;
					stored[slot] = w.value;
					age[slot]    = 0;
				end
			end
			return r;
		endfunction

		function void note_request(req_word_t w);
			words_due.push_back(lookup_and_update(w));
		endfunction

		task report(string what);
			if (errors < 40)
				$display("MISMATCH at %0t: %s", $time, what);
			errors++;
		endtask

		task check_response(rsp_word_t got);
			rsp_word_t want;
			if (words_due.size() == 0) begin
				report("response word with no request outstanding");
				return;
			end
			want = words_due.pop_front();
			if (got.hit !== want.hit)
				report($sformatf("hit got %0b want %0b", got.hit, want.hit));
			if (got.read_data !== want.read_data)
				report($sformatf("read_data got %0d want %0d",
					got.read_data, want.read_data));
			if (got.evicted !== want.evicted)
				report($sformatf("evicted got %0b want %0b", got.evicted, want.evicted));
		endtask
	endclass
endpackage

module lru_key_value_cache_unit_tb;
	import lkvc_pkg::*;
	import lkvc_tb_pkg::*;

	localparam int ENTRIES = SLOTS;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

	logic clk;
	logic arst_n;

	lkvc_chan_if #(.T(req_word_t)) req_if ();
	lkvc_chan_if #(.T(rsp_word_t)) rsp_if ();
	lkvc_chan_if #(.T(cfg_word_t)) cfg_if ();

	lru_key_value_cache_unit #(.ENTRIES(ENTRIES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	lru_mirror sb;

	int                 words_out;     // response words taken so far
	bit                 calm_sender;   // no gaps between request words
	int                 cap_pick;
	logic signed [31:0] key_pool [$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("lru_key_value_cache_unit_tb: done, errors");
		$finish;
	end

	// Monitor: everything is sampled on the rising edge. A response is
	// checked before a request on the same edge is noted, since the
	// response always belongs to an earlier request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				sb.check_response(rsp_if.data);
				words_out++;
			end
			if (req_if.valid && req_if.ready)
				sb.note_request(req_if.data);
			if (cfg_if.valid && cfg_if.ready)
				sb.write_capacity(cfg_if.data.capacity);
		end
	end

	// Response side back-pressure. Mostly ready, with short and long
	// stalls, calm stretches, and one long hold-off once traffic is
	// flowing so the cache backs up and refuses requests.
	initial begin
		int  stall_left;
		int  calm_left;
		int  r;
		bit  hold_done;
		stall_left = 0;
		calm_left  = 0;
		hold_done  = 1'b0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && words_out >= 200) begin
				hold_done = 1'b1;
				rsp_if.ready <= 1'b0;
				repeat (400) @(negedge clk);
			end else if (stall_left > 0) begin
				rsp_if.ready <= 1'b0;
				stall_left--;
			end else if (calm_left > 0) begin
				rsp_if.ready <= 1'b1;
				calm_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					calm_left = $urandom_range(50, 200);
					rsp_if.ready <= 1'b1;
				end else if (r < 28) begin
					stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40)
						: $urandom_range(1, 3);
					stall_left--;
					rsp_if.ready <= 1'b0;
				end else begin
					rsp_if.ready <= 1'b1;
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_sender || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// One request word; valid drops afterwards only if a gap is drawn.
	task automatic send_request(input logic op, input logic signed [31:0] k,
		input logic signed [31:0] v);
		req_word_t w;
		int        gap;
		w.operation = op;
		w.key       = k;
		w.value     = v;
		@(negedge clk);
		req_if.data  <= w;
		req_if.valid <= 1'b1;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drop_request_valid();
		@(negedge clk);
		req_if.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.words_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity_reg(input logic [CAP_W-1:0] v);
		cfg_word_t w;
		w.capacity = v;
		@(negedge clk);
		cfg_if.data  <= w;
		cfg_if.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return KEY_MIN;
			1:       return KEY_MAX;
			2:       return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	// Mostly keys from a pool a little larger than the capacity, so that
	// hits, updates and evictions all come up; the rest are fresh keys.
	task automatic random_phase(input int n);
		logic signed [31:0] k;
		logic               op;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			else
				k = $urandom();
			op = ($urandom_range(0, 1) == 0) ? OP_GET : OP_PUT;
			send_request(op, k, pick_value());
		end
		drop_request_valid();
	endtask

	task automatic refresh_pool();
		int n;
		key_pool.delete();
		key_pool.push_back(KEY_MIN);
		key_pool.push_back(KEY_MAX);
		key_pool.push_back(32'sd0);
		key_pool.push_back(-32'sd1);
		n = sb.capacity + 4;
		while (key_pool.size() < n)
			key_pool.push_back($urandom());
	endtask

	initial begin
		int final_cap;
		sb           = new();
		arst_n       = 1'b0;
		calm_sender  = 1'b0;
		words_out    = 0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Capacity only sticks while the cache is empty. Gets on an empty
		// cache leave it empty, so several settings can be walked through
		// before the first put freezes the last one.
		write_capacity_reg(5'd0);          // zero saturates to one
		send_request(OP_GET, 32'sd0, 32'sd0);
		send_request(OP_GET, KEY_MAX, KEY_MIN);
		drop_request_valid();
		wait_drained();
		write_capacity_reg(5'd31);         // above ENTRIES saturates
		send_request(OP_GET, KEY_MIN, KEY_MAX);
		drop_request_valid();
		wait_drained();
		cap_pick = $urandom_range(0, 3);
		final_cap = (cap_pick == 0) ? 1 : (cap_pick == 1) ? 16 : $urandom_range(2, 15);
		write_capacity_reg(final_cap[CAP_W-1:0]);

		// Directed: extreme keys and values, hit, update, fill and evict.
		send_request(OP_GET, 32'sd0, 32'sd5);      // miss on empty
		send_request(OP_PUT, KEY_MIN, KEY_MAX);
		send_request(OP_PUT, KEY_MAX, KEY_MIN);
		send_request(OP_GET, KEY_MIN, 32'sd0);
		send_request(OP_PUT, KEY_MAX, 32'sd0);     // update in place
		send_request(OP_GET, KEY_MAX, -32'sd1);
		send_request(OP_PUT, -32'sd1, -32'sd1);
		for (int i = 0; i <= final_cap; i++)
			send_request(OP_PUT, 32'sd100 + i, i);
		send_request(OP_GET, KEY_MIN, 32'sd0);     // long since evicted
		send_request(OP_GET, 32'sd100 + final_cap, 32'sd0);
		drop_request_valid();
		wait_drained();

		// Random phases. The capacity writes between them land on a
		// non-empty cache and must be ignored.
		for (int p = 0; p < 4; p++) begin
			refresh_pool();
			calm_sender = (p == 2);
			random_phase(250);
			wait_drained();
			write_capacity_reg((p % 2 == 0) ? 5'd0 : 5'd31);
		end

		wait_drained();
		repeat (ENTRIES + 6) @(posedge clk);
		if (sb.errors == 0)
			$display("lru_key_value_cache_unit_tb: done, clean");
		else
			$display("lru_key_value_cache_unit_tb: done, errors");
		$finish;
	end

endmodule
